// ===== hw/rtl/ebds_pkg.sv =====
// Shared constants and types of the edge batch degree statistics block.
package ebds_pkg;

   // Capacity of the degree stores and the edge counter.
   localparam int MAX_VERTICES  = 1024;
   localparam int MAX_EDGES     = 65536;
   localparam int FRACTION_BITS = 16;

   // Field and store widths.
   localparam int VID_W      = 10;
   localparam int ADDR_W     = $clog2(MAX_VERTICES);
   localparam int SPAN_W     = 11;
   localparam int EDGE_CNT_W = $clog2(MAX_EDGES + 1);
   localparam int TOT_W      = 18;
   localparam int HALF_W     = 17;
   localparam int NUM_LANES  = 3;

   // Moment sums: S1 < 2^18, S2 <= 2^34, S3 <= 2^51.
   localparam int S1_W = 18;
   localparam int S2_W = 35;
   localparam int S3_W = 52;

   // Arithmetic units of the final moment sequencer.
   localparam int WIDE_W = 200;
   localparam int MULB_W = 100;
   localparam int DIVQ_W = 64;
   localparam int DIVD_W = 21;
   localparam int DIVR_W = 22;
   localparam int DIVC_W = $clog2(DIVQ_W);
   localparam int NN_W   = 21;

   // Result fields.
   localparam int MEAN_W     = 34;
   localparam int VAR_W      = 51;
   localparam int SKEW_W     = 32;
   localparam int ROOT_W     = 31;
   localparam int ROOT_BIT_W = 5;

   // Result selector codes.
   typedef logic [1:0] which_type;
   localparam which_type WHICH_TOTAL = 2'd0;
   localparam which_type WHICH_IN    = 2'd1;
   localparam which_type WHICH_OUT   = 2'd2;

   typedef struct packed {
      logic [VID_W-1:0] source_vertex;
      logic [VID_W-1:0] dest_vertex;
      logic             last_edge;
   } req_payload_type;

   typedef struct packed {
      which_type               which_degree;
      logic [SPAN_W-1:0]       vertex_span;
      logic [TOT_W-1:0]        max_degree;
      logic [MEAN_W-1:0]       mean_fixed;
      logic [VAR_W-1:0]        variance_fixed;
      logic signed [SKEW_W-1:0] skew_fixed;
      logic                    zero_variance;
      logic                    edges_dropped;
      logic                    last_result;
   } rsp_payload_type;

   // One word of the degree memory: all three counters of a vertex.
   typedef struct packed {
      logic [TOT_W-1:0]  total;
      logic [HALF_W-1:0] in_deg;
      logic [HALF_W-1:0] out_deg;
   } deg_word_type;

endpackage

// ===== hw/rtl/ebds_if.sv =====
// Valid/ready channel interfaces for edge items and result items.
interface ebds_req_if
   import ebds_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ebds_rsp_if
   import ebds_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/edge_batch_degree_statistics.sv =====
// Top level: degree counting over an edge batch and degree moment statistics.
//
// req_ch carries one directed edge per item (source, destination, last flag).
// An edge is read-modify-written into one degree memory holding total, in and
// out degree per vertex, in steps set by the single memory port pair (read
// source, write source and read destination, write destination).
// Edges with an out-of-range id or beyond the edge capacity are dropped and flagged.
// After the last edge a sweep reads vertices 0 to the largest id seen, clears
// them, and accumulates the sums.
// A shared shift-add multiplier (one bit of the multiplier per cycle) and a
// restoring divider then derive mean, variance and skewness for the total, in
// and out lanes in turn; the skew root search tests 31 bits.
// A batch ends in three results; rsp_ch carries them in that order.
// Results wait in an output register; while it is full the sequencer holds.
// After the third result is loaded, edges of the next batch are accepted.
// After reset every vertex of the memory is cleared to zero before the first
// edge is accepted.
module edge_batch_degree_statistics
   import ebds_pkg::*;
(
   input logic        clock,
   input logic        reset,
   ebds_req_if.sink   req_ch,
   ebds_rsp_if.source rsp_ch
);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_EDGE_SRC, ST_EDGE_DST, ST_PASS, ST_LANE,
      ST_GOT_NS2, ST_GOT_S1SQ, ST_GOT_MEAN, ST_GOT_VAR, ST_GOT_CUBE,
      ST_GOT_NNS3, ST_GOT_NS1, ST_GOT_TNEG, ST_GOT_U2, ST_GOT_DD,
      ST_GOT_D3, ST_SRCH, ST_SRCH_CMP, ST_MUL, ST_DIV, ST_EMIT
   } state_type;

   state_type state_ff, ret_ff;

   // Degree memory and its ports.
   deg_word_type deg_mem_ff [MAX_VERTICES];
   deg_word_type rd_ff;
   deg_word_type fwd_ff;
   deg_word_type wr_data;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic wr_en;

   // Batch registers.
   logic [VID_W-1:0]      src_ff, dst_ff, largest_ff;
   logic                  last_ff, overflow_ff;
   logic [EDGE_CNT_W-1:0] edges_ff;
   logic [ADDR_W:0]       pass_addr_ff;
   logic                  pass_issue;

   // Sweep pipeline and sums per lane.
   logic                  p0_ff, pa_ff, pb_ff;
   logic [TOT_W-1:0]      x_ff [NUM_LANES];
   logic [S2_W-1:0]       sq_ff [NUM_LANES];
   logic [S3_W-1:0]       cube_ff [NUM_LANES];
   logic [S1_W-1:0]       s1_ff [NUM_LANES];
   logic [S2_W-1:0]       s2_ff [NUM_LANES];
   logic [S3_W-1:0]       s3_ff [NUM_LANES];
   logic [TOT_W-1:0]      mx_ff [NUM_LANES];
   logic [TOT_W-1:0]      lane_x [NUM_LANES];
   logic [2*TOT_W-1:0]    sq_in [NUM_LANES];
   logic [S2_W+TOT_W-1:0] cube_in [NUM_LANES];

   // Moment sequencer.
   which_type              lane_ff;
   logic [WIDE_W-1:0]      mul_a_ff, mul_acc_ff;
   logic [MULB_W-1:0]      mul_b_ff;
   logic [DIVQ_W-1:0]      div_q_ff;
   logic [DIVR_W-1:0]      div_rem_ff, div_shift, div_sub;
   logic [DIVD_W-1:0]      div_d_ff;
   logic [DIVC_W-1:0]      div_cnt_ff;
   logic                   div_ge;
   logic [WIDE_W-1:0]      d_ff, s1sq_ff, tpos_ff, u_ff, t_diff;
   logic [NN_W-1:0]        nn_ff;
   logic [2*SPAN_W-1:0]    nn_in;
   logic [SPAN_W+1:0]      n3;
   logic [ROOT_W-1:0]      k_ff, cand;
   logic [ROOT_BIT_W-1:0]  srch_bit_ff;
   logic [2*ROOT_W-1:0]    csq_in;
   logic                   neg_ff, zero_ff;
   logic [MEAN_W-1:0]      mean_ff, mean_sat;
   logic [VAR_W-1:0]       var_ff, var_sat;
   logic [SPAN_W-1:0]      span;
   logic [VID_W-1:0]       lg_src, lg_both;
   logic                   edge_ok, emit_go, rsp_load;
   logic [S1_W-1:0]        s1_sel;
   logic [S2_W-1:0]        s2_sel;
   logic [S3_W-1:0]        s3_sel;

   // Output register.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // Batch bookkeeping values.
   assign span    = SPAN_W'(largest_ff) + SPAN_W'(1);
   assign lg_src  = (req_ch.data.source_vertex > largest_ff) ? req_ch.data.source_vertex
                                                              : largest_ff;
   assign lg_both = (req_ch.data.dest_vertex > lg_src) ? req_ch.data.dest_vertex : lg_src;
   assign edge_ok = (int'(req_ch.data.source_vertex) < MAX_VERTICES) &&
                    (int'(req_ch.data.dest_vertex) < MAX_VERTICES) &&
                    (edges_ff < EDGE_CNT_W'(MAX_EDGES));
   assign emit_go  = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_load = (state_ff == ST_EMIT) && emit_go;

   // Lane selection for the sequencer.
   assign s1_sel = s1_ff[lane_ff];
   assign s2_sel = s2_ff[lane_ff];
   assign s3_sel = s3_ff[lane_ff];

   // Divider step, root candidate and other datapath terms.
   always_comb begin
      div_shift = {div_rem_ff[DIVR_W-2:0], div_q_ff[DIVQ_W-1]};
      div_ge    = div_shift >= DIVR_W'(div_d_ff);
      div_sub   = div_shift - DIVR_W'(div_d_ff);
      mean_sat  = (|div_q_ff[DIVQ_W-1:MEAN_W]) ? '1 : div_q_ff[MEAN_W-1:0];
      var_sat   = (|div_q_ff[DIVQ_W-1:VAR_W]) ? '1 : div_q_ff[VAR_W-1:0];
      cand      = k_ff | (ROOT_W'(1) << srch_bit_ff);
      csq_in    = cand * cand;
      nn_in     = span * span;
      n3        = (SPAN_W + 2)'(span) + ((SPAN_W + 2)'(span) << 1);
      t_diff    = (tpos_ff >= mul_acc_ff) ? (tpos_ff - mul_acc_ff) : (mul_acc_ff - tpos_ff);
   end

   // Sweep pipeline products per lane.
   always_comb begin
      lane_x[WHICH_TOTAL] = rd_ff.total;
      lane_x[WHICH_IN]    = TOT_W'(rd_ff.in_deg);
      lane_x[WHICH_OUT]   = TOT_W'(rd_ff.out_deg);
      for (int l = 0; l < NUM_LANES; l++) begin
         sq_in[l]   = lane_x[l] * lane_x[l];
         cube_in[l] = sq_ff[l] * x_ff[l];
      end
   end

   // Memory port control.
   always_comb begin
      rd_addr    = req_ch.data.source_vertex[ADDR_W-1:0];
      wr_en      = 1'b0;
      wr_addr    = pass_addr_ff[ADDR_W-1:0];
      wr_data    = '0;
      pass_issue = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_EDGE_SRC: begin
            wr_en           = 1'b1;
            wr_addr         = src_ff[ADDR_W-1:0];
            wr_data         = rd_ff;
            wr_data.total   = rd_ff.total + TOT_W'(1);
            wr_data.out_deg = rd_ff.out_deg + HALF_W'(1);
            rd_addr         = dst_ff[ADDR_W-1:0];
         end
         ST_EDGE_DST: begin
            wr_en          = 1'b1;
            wr_addr        = dst_ff[ADDR_W-1:0];
            wr_data        = (dst_ff == src_ff) ? fwd_ff : rd_ff;
            wr_data.total  = wr_data.total + TOT_W'(1);
            wr_data.in_deg = wr_data.in_deg + HALF_W'(1);
         end
         ST_PASS: begin
            rd_addr = pass_addr_ff[ADDR_W-1:0];
            if (pass_addr_ff < span) begin
               pass_issue = 1'b1;
               wr_en      = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Degree memory: one write and one registered read per cycle, read first.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         deg_mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= deg_mem_ff[rd_addr];
   end

   // Control sequencer with sweep pipeline, arithmetic units and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ret_ff       <= ST_IDLE;
         pass_addr_ff <= '0;
         largest_ff   <= '0;
         edges_ff     <= '0;
         overflow_ff  <= 1'b0;
         lane_ff      <= WHICH_TOTAL;
         p0_ff        <= 1'b0;
         pa_ff        <= 1'b0;
         pb_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Sweep pipeline: square, then cube, sums and maximum, then cube sum.
         p0_ff <= pass_issue;
         pa_ff <= p0_ff;
         pb_ff <= pa_ff;
         for (int l = 0; l < NUM_LANES; l++) begin
            if (p0_ff) begin
               x_ff[l]  <= lane_x[l];
               sq_ff[l] <= S2_W'(sq_in[l]);
            end
            if (pa_ff) begin
               cube_ff[l] <= S3_W'(cube_in[l]);
               s1_ff[l]   <= s1_ff[l] + S1_W'(x_ff[l]);
               s2_ff[l]   <= s2_ff[l] + sq_ff[l];
               if (x_ff[l] > mx_ff[l]) begin
                  mx_ff[l] <= x_ff[l];
               end
            end
            if (pb_ff) begin
               s3_ff[l] <= s3_ff[l] + cube_ff[l];
            end
         end

         // The output register fills from the sequencer and empties when the
         // receiver takes the item.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_CLEAR: begin
               if (pass_addr_ff == (ADDR_W + 1)'(MAX_VERTICES - 1)) begin
                  state_ff <= ST_IDLE;
               end
               pass_addr_ff <= pass_addr_ff + (ADDR_W + 1)'(1);
            end

            ST_IDLE: begin
               if (req_ch.valid) begin
                  src_ff  <= req_ch.data.source_vertex;
                  dst_ff  <= req_ch.data.dest_vertex;
                  last_ff <= req_ch.data.last_edge;
                  if (edge_ok) begin
                     largest_ff <= lg_both;
                     edges_ff   <= edges_ff + EDGE_CNT_W'(1);
                     state_ff   <= ST_EDGE_SRC;
                  end else begin
                     overflow_ff <= 1'b1;
                     if (req_ch.data.last_edge) begin
                        state_ff     <= ST_PASS;
                        pass_addr_ff <= '0;
                        for (int l = 0; l < NUM_LANES; l++) begin
                           s1_ff[l] <= '0;
                           s2_ff[l] <= '0;
                           s3_ff[l] <= '0;
                           mx_ff[l] <= '0;
                        end
                     end
                  end
               end
            end

            ST_EDGE_SRC: begin
               fwd_ff   <= wr_data;
               state_ff <= ST_EDGE_DST;
            end

            ST_EDGE_DST: begin
               if (last_ff) begin
                  state_ff     <= ST_PASS;
                  pass_addr_ff <= '0;
                  for (int l = 0; l < NUM_LANES; l++) begin
                     s1_ff[l] <= '0;
                     s2_ff[l] <= '0;
                     s3_ff[l] <= '0;
                     mx_ff[l] <= '0;
                  end
               end else begin
                  state_ff <= ST_IDLE;
               end
            end

            // Sweep the summarized vertices, clearing each one as it is read.
            ST_PASS: begin
               if (pass_issue) begin
                  pass_addr_ff <= pass_addr_ff + (ADDR_W + 1)'(1);
               end else if (!p0_ff && !pa_ff && !pb_ff) begin
                  nn_ff    <= NN_W'(nn_in);
                  lane_ff  <= WHICH_TOTAL;
                  state_ff <= ST_LANE;
               end
            end

            // D = n*S2 - S1^2, then mean = S1/n and variance = D/n^2.
            ST_LANE: begin
               mul_a_ff   <= WIDE_W'(s2_sel);
               mul_b_ff   <= MULB_W'(span);
               mul_acc_ff <= '0;
               ret_ff     <= ST_GOT_NS2;
               state_ff   <= ST_MUL;
            end
            ST_GOT_NS2: begin
               d_ff       <= mul_acc_ff;
               mul_a_ff   <= WIDE_W'(s1_sel);
               mul_b_ff   <= MULB_W'(s1_sel);
               mul_acc_ff <= '0;
               ret_ff     <= ST_GOT_S1SQ;
               state_ff   <= ST_MUL;
            end
            ST_GOT_S1SQ: begin
               d_ff       <= d_ff - mul_acc_ff;
               s1sq_ff    <= mul_acc_ff;
               div_q_ff   <= DIVQ_W'(s1_sel) << FRACTION_BITS;
               div_rem_ff <= '0;
               div_d_ff   <= DIVD_W'(span);
               div_cnt_ff <= DIVC_W'(DIVQ_W - 1);
               ret_ff     <= ST_GOT_MEAN;
               state_ff   <= ST_DIV;
            end
            ST_GOT_MEAN: begin
               mean_ff    <= mean_sat;
               div_q_ff   <= DIVQ_W'(d_ff[DIVQ_W-FRACTION_BITS-1:0]) << FRACTION_BITS;
               div_rem_ff <= '0;
               div_d_ff   <= nn_ff;
               div_cnt_ff <= DIVC_W'(DIVQ_W - 1);
               ret_ff     <= ST_GOT_VAR;
               state_ff   <= ST_DIV;
            end
            ST_GOT_VAR: begin
               var_ff <= var_sat;
               if (d_ff == '0) begin
                  zero_ff  <= 1'b1;
                  neg_ff   <= 1'b0;
                  k_ff     <= '0;
                  state_ff <= ST_EMIT;
               end else begin
                  zero_ff    <= 1'b0;
                  mul_a_ff   <= s1sq_ff;
                  mul_b_ff   <= MULB_W'(s1_sel);
                  mul_acc_ff <= '0;
                  ret_ff     <= ST_GOT_CUBE;
                  state_ff   <= ST_MUL;
               end
            end

            // T = n^2*S3 + 2*S1^3 - 3*n*S1*S2, split into positive and negative parts.
            ST_GOT_CUBE: begin
               tpos_ff    <= mul_acc_ff << 1;
               mul_a_ff   <= WIDE_W'(s3_sel);
               mul_b_ff   <= MULB_W'(nn_ff);
               mul_acc_ff <= '0;
               ret_ff     <= ST_GOT_NNS3;
               state_ff   <= ST_MUL;
            end
            ST_GOT_NNS3: begin
               tpos_ff    <= tpos_ff + mul_acc_ff;
               mul_a_ff   <= WIDE_W'(s1_sel);
               mul_b_ff   <= MULB_W'(n3);
               mul_acc_ff <= '0;
               ret_ff     <= ST_GOT_NS1;
               state_ff   <= ST_MUL;
            end
            ST_GOT_NS1: begin
               mul_a_ff   <= mul_acc_ff;
               mul_b_ff   <= MULB_W'(s2_sel);
               mul_acc_ff <= '0;
               ret_ff     <= ST_GOT_TNEG;
               state_ff   <= ST_MUL;
            end
            ST_GOT_TNEG: begin
               neg_ff     <= tpos_ff < mul_acc_ff;
               mul_a_ff   <= t_diff << FRACTION_BITS;
               mul_b_ff   <= MULB_W'(t_diff << FRACTION_BITS);
               mul_acc_ff <= '0;
               ret_ff     <= ST_GOT_U2;
               state_ff   <= ST_MUL;
            end

            // u^2 and D^3 for the root search.
            ST_GOT_U2: begin
               u_ff       <= mul_acc_ff;
               mul_a_ff   <= d_ff;
               mul_b_ff   <= MULB_W'(d_ff);
               mul_acc_ff <= '0;
               ret_ff     <= ST_GOT_DD;
               state_ff   <= ST_MUL;
            end
            ST_GOT_DD: begin
               mul_a_ff   <= mul_acc_ff;
               mul_b_ff   <= MULB_W'(d_ff);
               mul_acc_ff <= '0;
               ret_ff     <= ST_GOT_D3;
               state_ff   <= ST_MUL;
            end
            ST_GOT_D3: begin
               d_ff        <= mul_acc_ff;
               k_ff        <= '0;
               srch_bit_ff <= ROOT_BIT_W'(ROOT_W - 1);
               state_ff    <= ST_SRCH;
            end

            // Largest k with k^2 * D^3 <= u^2, one bit per round.
            ST_SRCH: begin
               mul_a_ff   <= d_ff;
               mul_b_ff   <= MULB_W'(csq_in);
               mul_acc_ff <= '0;
               ret_ff     <= ST_SRCH_CMP;
               state_ff   <= ST_MUL;
            end
            ST_SRCH_CMP: begin
               if (mul_acc_ff <= u_ff) begin
                  k_ff <= cand;
               end
               if (srch_bit_ff == '0) begin
                  state_ff <= ST_EMIT;
               end else begin
                  srch_bit_ff <= srch_bit_ff - ROOT_BIT_W'(1);
                  state_ff    <= ST_SRCH;
               end
            end

            // Shift-add multiplier: one bit of the B operand per cycle.
            ST_MUL: begin
               if (mul_b_ff == '0) begin
                  state_ff <= ret_ff;
               end else begin
                  if (mul_b_ff[0]) begin
                     mul_acc_ff <= mul_acc_ff + mul_a_ff;
                  end
                  mul_a_ff <= mul_a_ff << 1;
                  mul_b_ff <= mul_b_ff >> 1;
               end
            end

            // Restoring divider: one quotient bit per cycle.
            ST_DIV: begin
               div_q_ff   <= {div_q_ff[DIVQ_W-2:0], div_ge};
               div_rem_ff <= div_ge ? div_sub : div_shift;
               if (div_cnt_ff == '0) begin
                  state_ff <= ret_ff;
               end else begin
                  div_cnt_ff <= div_cnt_ff - DIVC_W'(1);
               end
            end

            // Hand the result to the output register once it is free.
            ST_EMIT: begin
               if (emit_go) begin
                  rsp_data_ff.which_degree    <= lane_ff;
                  rsp_data_ff.vertex_span     <= span;
                  rsp_data_ff.max_degree      <= mx_ff[lane_ff];
                  rsp_data_ff.mean_fixed      <= mean_ff;
                  rsp_data_ff.variance_fixed  <= var_ff;
                  rsp_data_ff.skew_fixed      <= neg_ff ? -SKEW_W'(k_ff) : SKEW_W'(k_ff);
                  rsp_data_ff.zero_variance   <= zero_ff;
                  rsp_data_ff.edges_dropped   <= overflow_ff;
                  rsp_data_ff.last_result     <= (lane_ff == WHICH_OUT);
                  if (lane_ff == WHICH_OUT) begin
                     largest_ff  <= '0;
                     edges_ff    <= '0;
                     overflow_ff <= 1'b0;
                     state_ff    <= ST_IDLE;
                  end else begin
                     lane_ff  <= lane_ff + which_type'(1);
                     state_ff <= ST_LANE;
                  end
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // The final result of a batch is exactly the out-degree result.
   a_last_lane: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.data.last_result == (rsp_ch.data.which_degree == WHICH_OUT)))
      else $error("last_result does not match the out-degree result");

   // A zero variance always comes with a zero skew.
   a_zero_skew: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.data.zero_variance) |-> (rsp_ch.data.skew_fixed == '0))
      else $error("nonzero skew reported with zero variance");

   // The sweep pipeline drains before the sequencer leaves the sweep.
   a_sweep_drain: assert property (@(posedge clock) disable iff (reset)
      (p0_ff || pa_ff || pb_ff) |-> (state_ff == ST_PASS))
      else $error("sweep data in flight after the sweep ended");

endmodule
